// ----- hdl/mlpt_pkg.sv -----
// ----------------------------------------------------------------------------
// mlpt_pkg: shared definitions for the multi-level page table walker
// Geometry constants, sequencer states, status codes and the index split.
// ----------------------------------------------------------------------------
package mlpt_pkg;

    localparam int PAGE_OFFSET_BITS = 12;
    localparam int LEVEL_COUNT      = 4;
    localparam int FRAME_COUNT      = 64;

    localparam int INDEX_BITS    = PAGE_OFFSET_BITS - 3;
    localparam int TABLE_ENTRIES = 1 << INDEX_BITS;
    localparam int STORE_DEPTH   = FRAME_COUNT * TABLE_ENTRIES;
    localparam int FRAME_BITS    = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int ENTRY_W       = FRAME_BITS + 1;
    localparam int ADDR_W        = FRAME_BITS + INDEX_BITS;
    localparam int FREE_W        = $clog2(FRAME_COUNT + 1);
    localparam int LEVEL_W       = $clog2(LEVEL_COUNT + 1);
    localparam int IDX_VEC_W     = LEVEL_COUNT * INDEX_BITS;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_ADD,
        S_RESP
    } t_state;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_UNMAPPED = 2'd1,
        STAT_NOFRAME  = 2'd2
    } t_status;

    // Pack all level index fields, level 1 in the top field; fields above
    // bit 63 read as zero.
    function automatic logic [IDX_VEC_W-1:0] split_index(input logic [63:0] va);
        logic [IDX_VEC_W-1:0] v;
        int                   sh;
        v = '0;
        for (int k = 0; k < LEVEL_COUNT; k++) begin
            sh = PAGE_OFFSET_BITS + INDEX_BITS * k;
            if (sh < 64) begin
                v[k*INDEX_BITS +: INDEX_BITS] = INDEX_BITS'(va >> sh);
            end
        end
        return v;
    endfunction

endpackage

// ----- hdl/mlpt_ram.sv -----
// ----------------------------------------------------------------------------
// mlpt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mlpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/multi_level_page_table_walker.sv -----
// ----------------------------------------------------------------------------
// multi_level_page_table_walker: page table walk with bump frame allocation
// Each walk goes from accept through a table read state and a check state
// per level, then an add state, to the result; a not-mapped or out-of-frames
// exit goes straight to the result. A new transaction is accepted only once
// the previous result has been taken. Reset: a clearing pass zeroes all
// STORE_DEPTH (32768) table store entries; o_ready stays low until it ends. Config writes are taken throughout.
// ----------------------------------------------------------------------------
module multi_level_page_table_walker
    import mlpt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [63:0] i_virtual_address,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_physical_address,
    output logic [1:0]  o_status
);

    t_state                        r_state, n_state;
    logic [ADDR_W-1:0]             r_clr_addr, n_clr_addr;
    logic                          r_root, n_root;
    logic [FREE_W-1:0]             r_next_free, n_next_free;
    logic [63:0]                   r_base, n_base;
    logic                          r_mode, n_mode;
    logic [PAGE_OFFSET_BITS-1:0]   r_offset, n_offset;
    logic [IDX_VEC_W-1:0]          r_idx, n_idx;
    logic [FRAME_BITS-1:0]         r_frame, n_frame;
    logic [LEVEL_W-1:0]            r_level, n_level;
    logic [63:0]                   r_phys, n_phys;
    t_status                       r_status, n_status;

    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic [ENTRY_W-1:0]            ram_wdata;
    logic [ADDR_W-1:0]             ram_raddr;
    logic [ENTRY_W-1:0]            ram_rdata;
    logic [ADDR_W-1:0]             cur_addr;
    logic                          frames_full;

    mlpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cur_addr    = {r_frame, r_idx[IDX_VEC_W-1 -: INDEX_BITS]};
    assign frames_full = (r_next_free == FREE_W'(FRAME_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_root      <= 1'b0;
            r_next_free <= '0;
            r_base      <= '0;
            r_level     <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_root      <= n_root;
            r_next_free <= n_next_free;
            r_base      <= n_base;
            r_level     <= n_level;
        end
        r_mode   <= n_mode;
        r_offset <= n_offset;
        r_idx    <= n_idx;
        r_frame  <= n_frame;
        r_phys   <= n_phys;
        r_status <= n_status;
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_root      = r_root;
        n_next_free = r_next_free;
        n_base      = i_cfg_we ? i_cfg_wdata : r_base;
        n_mode      = r_mode;
        n_offset    = r_offset;
        n_idx       = r_idx;
        n_frame     = r_frame;
        n_level     = r_level;
        n_phys      = r_phys;
        n_status    = r_status;
        ram_we      = 1'b0;
        ram_waddr   = cur_addr;
        ram_wdata   = '0;
        ram_raddr   = cur_addr;

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_mode   = i_mode;
                    n_offset = i_virtual_address[PAGE_OFFSET_BITS-1:0];
                    n_idx    = split_index(i_virtual_address);
                    n_frame  = '0;
                    n_level  = '0;
                    n_state  = S_READ;
                    if (!r_root) begin
                        if (!i_mode) begin
                            n_phys   = '0;
                            n_status = STAT_UNMAPPED;
                            n_state  = S_RESP;
                        end else if (frames_full) begin
                            n_phys   = '0;
                            n_status = STAT_NOFRAME;
                            n_state  = S_RESP;
                        end else begin
                            n_root      = 1'b1;
                            n_next_free = r_next_free + 1'b1;
                        end
                    end
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (ram_rdata[0] || r_mode) begin
                    if (ram_rdata[0]) begin
                        n_frame = ram_rdata[ENTRY_W-1:1];
                    end else begin
                        ram_we      = 1'b1;
                        ram_wdata   = {FRAME_BITS'(r_next_free), 1'b1};
                        n_frame     = FRAME_BITS'(r_next_free);
                        n_next_free = r_next_free + 1'b1;
                    end
                    if (r_level == LEVEL_W'(LEVEL_COUNT - 1)) begin
                        n_state = S_ADD;
                    end else begin
                        n_level = r_level + 1'b1;
                        n_idx   = r_idx << INDEX_BITS;
                        n_state = S_READ;
                    end
                end
                // drop out: not mapped, or no frame left to allocate
                if (!ram_rdata[0] && !r_mode) begin
                    n_phys   = '0;
                    n_status = STAT_UNMAPPED;
                    n_state  = S_RESP;
                end else if (!ram_rdata[0] && frames_full) begin
                    ram_we      = 1'b0;
                    n_frame     = r_frame;
                    n_next_free = r_next_free;
                    n_level     = r_level;
                    n_idx       = r_idx;
                    n_phys      = '0;
                    n_status    = STAT_NOFRAME;
                    n_state     = S_RESP;
                end
            end
            S_ADD: begin
                n_phys   = r_base + 64'({r_frame, r_offset});
                n_status = STAT_OK;
                n_state  = S_RESP;
            end
            S_RESP: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready            = (r_state == S_IDLE);
    assign o_valid            = (r_state == S_RESP);
    assign o_physical_address = r_phys;
    assign o_status           = r_status;

endmodule
